FILE: sv/homogeneous_triangle_clipper_unit_assert.svh
// Assertion macros shared by the clipper RTL.
`ifndef HOMOGENEOUS_TRIANGLE_CLIPPER_UNIT_ASSERT_SVH
`define HOMOGENEOUS_TRIANGLE_CLIPPER_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define HTC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("clipper check failed");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define HTC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("clipper check failed");

`endif

FILE: sv/htc_pkg.sv
// Shared types, constants and helpers of the homogeneous triangle clipper.
package htc_pkg;
    localparam int MAX_POLY_VERTS = 9;
    localparam int T_BITS = 30;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;
    localparam logic [1:0] AX_W = 2'd3;
    localparam logic [2:0] PLANE_LAST = 3'd5;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] w;
    } t_vtx;

    typedef struct packed {
        logic wr;
        logic shift;
    } t_cell_ctl;

    function automatic logic signed [31:0] vtx_get(t_vtx v, logic [1:0] k);
        logic signed [31:0] r;
        case (k)
            AX_X: r = v.x;
            AX_Y: r = v.y;
            AX_Z: r = v.z;
            default: r = v.w;
        endcase
        return r;
    endfunction

    function automatic t_vtx vtx_set(t_vtx v, logic [1:0] k, logic signed [31:0] val);
        t_vtx r;
        r = v;
        case (k)
            AX_X: r.x = val;
            AX_Y: r.y = val;
            AX_Z: r.z = val;
            default: r.w = val;
        endcase
        return r;
    endfunction
endpackage

FILE: sv/homogeneous_triangle_clipper_unit.sv
// Clipper top level: one triangle in, its clipped polygon out, one vertex per strobe.
// A triangle is taken when start is high and busy is low. Each of the six planes walks
// the polygon edges through a queue of vertex cells. A crossing edge runs a 31-step
// divide for t, then a multiply and a round for each coordinate, then pushes the new
// vertex and, when its far end is inside, that end too. The polygon then leaves at one
// vertex per cycle with o_valid high for exactly one cycle each and the last marked;
// the receiver cannot stall it, so it must take every strobe. A triangle fully outside
// gives no strobes at all.
`include "homogeneous_triangle_clipper_unit_assert.svh"
module homogeneous_triangle_clipper_unit #(
    parameter int MAX_POLY_VERTS = htc_pkg::MAX_POLY_VERTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_a_x,
    input  logic signed [31:0] i_a_y,
    input  logic signed [31:0] i_a_z,
    input  logic signed [31:0] i_a_w,
    input  logic signed [31:0] i_b_x,
    input  logic signed [31:0] i_b_y,
    input  logic signed [31:0] i_b_z,
    input  logic signed [31:0] i_b_w,
    input  logic signed [31:0] i_c_x,
    input  logic signed [31:0] i_c_y,
    input  logic signed [31:0] i_c_z,
    input  logic signed [31:0] i_c_w,
    output logic               o_valid,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    output logic signed [31:0] o_out_w,
    output logic               o_last_vertex
);
    import htc_pkg::*;

    localparam int NC = 2 * MAX_POLY_VERTS;
    localparam int CW = $clog2(NC + 1);
    localparam logic signed [35:0] SAT_MAX = 36'sd2147483647;
    localparam logic signed [35:0] SAT_MIN = -36'sd2147483648;
    localparam logic [63:0] RND_HALF = 64'd1 << (T_BITS - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_EDGE, S_DIV, S_MUL, S_RND, S_PUSHX, S_PUSHN, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic [2:0]        r_plane, n_plane;
    logic [CW-1:0]     r_nsrc, n_nsrc;
    logic [CW-1:0]     r_m, n_m;
    logic              r_fst, n_fst;
    t_vtx              r_first, n_first;
    t_vtx              r_cur, n_cur;
    t_vtx              r_nxt, n_nxt;
    t_vtx              r_x, n_x;
    logic              r_in1, n_in1;
    logic [T_BITS:0]   r_t, n_t;
    logic [1:0]        r_k, n_k;
    logic signed [63:0] r_prod, n_prod;
    logic              r_valid, n_valid;
    t_vtx              r_out, n_out;
    logic              r_last, n_last;

    t_vtx cell_v [NC];
    t_vtx abc_v [3];
    t_vtx cur_v, nxt_v, first_v, q_pushv;
    logic q_pop, q_push, q_push_req, edge_done, div_go, div_done, acc;
    logic [CW-1:0] widx, m_after;
    logic signed [33:0] d0, d1;
    logic in0, in1;
    logic [33:0] mag0, mag1;
    logic [T_BITS:0] quot;
    logic signed [32:0] delta;
    logic signed [64:0] mul_full;
    logic [63:0] pmag, psum;
    logic [33:0] qmag;
    logic signed [35:0] base, vsum;
    logic signed [31:0] sat;

    function automatic logic signed [33:0] plane_dist(t_vtx v, logic [2:0] p);
        logic signed [33:0] a;
        logic signed [33:0] w;
        a = 34'(vtx_get(v, p[2:1]));
        w = 34'(v.w);
        return p[0] ? (w - a) : (w + a);
    endfunction

    assign acc = start && (r_state == S_IDLE);
    assign busy = (r_state != S_IDLE);

    assign abc_v[0] = '{x: i_a_x, y: i_a_y, z: i_a_z, w: i_a_w};
    assign abc_v[1] = '{x: i_b_x, y: i_b_y, z: i_b_z, w: i_b_w};
    assign abc_v[2] = '{x: i_c_x, y: i_c_y, z: i_c_z, w: i_c_w};

    assign widx = r_nsrc + r_m - CW'(q_pop);

    for (genvar i = 0; i < NC; i++) begin : g_cell
        t_cell_ctl ctl;
        t_vtx      wr_v;
        t_vtx      nbr_v;
        always_comb begin
            if (i < 3) begin
                ctl.wr = acc || (q_push && (widx == CW'(i)));
                wr_v = acc ? abc_v[(i < 3) ? i : 0] : q_pushv;
            end else begin
                ctl.wr = q_push && (widx == CW'(i));
                wr_v = q_pushv;
            end
            ctl.shift = q_pop;
        end
        if (i < NC - 1) begin : g_mid
            assign nbr_v = cell_v[i+1];
        end else begin : g_end
            assign nbr_v = '0;
        end
        htc_vcell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_wr_v  (wr_v),
            .i_nbr_v (nbr_v),
            .o_v     (cell_v[i])
        );
    end

    assign cur_v = cell_v[0];
    assign first_v = r_fst ? cell_v[0] : r_first;
    assign nxt_v = (r_nsrc > CW'(1)) ? cell_v[1] : first_v;
    assign d0 = plane_dist(cur_v, r_plane);
    assign d1 = plane_dist(nxt_v, r_plane);
    assign in0 = !d0[33];
    assign in1 = !d1[33];
    assign mag0 = d0[33] ? 34'(-d0) : 34'(d0);
    assign mag1 = d1[33] ? 34'(-d1) : 34'(d1);

    htc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_go),
        .i_num   (mag0),
        .i_den   (mag0 + mag1),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    assign delta = 33'(vtx_get(r_nxt, r_k)) - 33'(vtx_get(r_cur, r_k));
    assign mul_full = delta * $signed({2'b00, r_t});
    assign pmag = r_prod[63] ? 64'(-r_prod) : 64'(r_prod);
    assign psum = pmag + RND_HALF;
    assign qmag = psum[T_BITS+33:T_BITS];
    assign base = 36'(vtx_get(r_cur, r_k));
    assign vsum = r_prod[63] ? (base - $signed({2'b00, qmag}))
                             : (base + $signed({2'b00, qmag}));
    assign sat = (vsum > SAT_MAX) ? 32'sh7fffffff :
                 (vsum < SAT_MIN) ? 32'sh80000000 : vsum[31:0];

    always_comb begin
        n_state = r_state;
        n_plane = r_plane;
        n_nsrc = r_nsrc;
        n_m = r_m;
        n_fst = r_fst;
        n_first = r_first;
        n_cur = r_cur;
        n_nxt = r_nxt;
        n_x = r_x;
        n_in1 = r_in1;
        n_t = r_t;
        n_k = r_k;
        n_prod = r_prod;
        n_valid = 1'b0;
        n_out = r_out;
        n_last = r_last;
        q_pop = 1'b0;
        q_push_req = 1'b0;
        q_pushv = r_x;
        edge_done = 1'b0;
        div_go = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_nsrc = CW'(3);
                    n_m = '0;
                    n_plane = '0;
                    n_fst = 1'b1;
                    n_state = S_EDGE;
                end
            end
            S_EDGE: begin
                n_first = first_v;
                n_fst = 1'b0;
                n_cur = cur_v;
                n_nxt = nxt_v;
                n_in1 = in1;
                q_pop = 1'b1;
                n_nsrc = r_nsrc - CW'(1);
                if (in0 && in1) begin
                    q_push_req = 1'b1;
                    q_pushv = nxt_v;
                    edge_done = 1'b1;
                end else if (!in0 && !in1) begin
                    edge_done = 1'b1;
                end else begin
                    div_go = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_t = quot;
                    n_k = AX_X;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod = mul_full[63:0];
                n_state = S_RND;
            end
            S_RND: begin
                n_x = vtx_set(r_x, r_k, sat);
                if (r_k == AX_W) begin
                    n_state = S_PUSHX;
                end else begin
                    n_k = r_k + 2'd1;
                    n_state = S_MUL;
                end
            end
            S_PUSHX: begin
                q_push_req = 1'b1;
                q_pushv = r_x;
                if (r_in1) begin
                    n_state = S_PUSHN;
                end else begin
                    edge_done = 1'b1;
                end
            end
            S_PUSHN: begin
                q_push_req = 1'b1;
                q_pushv = r_nxt;
                edge_done = 1'b1;
            end
            S_OUT: begin
                q_pop = 1'b1;
                n_nsrc = r_nsrc - CW'(1);
                n_valid = 1'b1;
                n_out = cur_v;
                n_last = (r_nsrc == CW'(1));
                if (r_nsrc == CW'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        q_push = q_push_req && (r_m < CW'(MAX_POLY_VERTS));
        m_after = r_m + CW'(q_push);
        if (q_push) begin
            n_m = m_after;
        end
        if (edge_done) begin
            if (n_nsrc == '0) begin
                n_m = '0;
                n_nsrc = m_after;
                n_fst = 1'b1;
                if (m_after == '0) begin
                    n_state = S_IDLE;
                end else if (r_plane == PLANE_LAST) begin
                    n_state = S_OUT;
                end else begin
                    n_plane = r_plane + 3'd1;
                    n_state = S_EDGE;
                end
            end else begin
                n_state = S_EDGE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_plane <= '0;
            r_nsrc <= '0;
            r_m <= '0;
            r_fst <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_plane <= n_plane;
            r_nsrc <= n_nsrc;
            r_m <= n_m;
            r_fst <= n_fst;
        end
        r_first <= n_first;
        r_cur <= n_cur;
        r_nxt <= n_nxt;
        r_x <= n_x;
        r_in1 <= n_in1;
        r_t <= n_t;
        r_k <= n_k;
        r_prod <= n_prod;
        r_out <= n_out;
        r_last <= n_last;
    end

    assign o_valid = r_valid;
    assign o_out_x = r_out.x;
    assign o_out_y = r_out.y;
    assign o_out_z = r_out.z;
    assign o_out_w = r_out.w;
    assign o_last_vertex = r_last;

    `HTC_ASSERT_NEXT(a_vertices_contiguous, o_valid && !o_last_vertex, o_valid)
    `HTC_ASSERT_NEXT(a_start_takes, start && !busy, busy)
    `HTC_ASSERT_NOW(a_queue_fits, 1'b1, (r_nsrc + r_m) <= CW'(NC))
    `HTC_ASSERT_NOW(a_stage_cap, 1'b1, r_m <= CW'(MAX_POLY_VERTS))
    `HTC_ASSERT_NOW(a_no_push_on_out, r_state == S_OUT, !q_push && !div_go)
endmodule

FILE: sv/htc_vcell.sv
// One vertex cell of the polygon queue: loads a vertex or takes its neighbor's.
module htc_vcell (
    input  logic              i_clk,
    input  htc_pkg::t_cell_ctl i_ctl,
    input  htc_pkg::t_vtx     i_wr_v,
    input  htc_pkg::t_vtx     i_nbr_v,
    output htc_pkg::t_vtx     o_v
);
    import htc_pkg::*;

    t_vtx r_v;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_v <= i_wr_v;
        end else if (i_ctl.shift) begin
            r_v <= i_nbr_v;
        end
    end

    assign o_v = r_v;
endmodule

FILE: sv/htc_div.sv
// Radix-2 restoring divider for the crossing parameter t = num * 2^T_BITS / den.
module htc_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [33:0]                  i_num,
    input  logic [33:0]                  i_den,
    output logic                         o_done,
    output logic [htc_pkg::T_BITS:0]     o_quot
);
    import htc_pkg::*;

    localparam int CNT_W = $clog2(T_BITS + 2);

    logic [34:0]      r_rem;
    logic [33:0]      r_den;
    logic [T_BITS:0]  r_q;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic             ge;
    logic [34:0]      rem_sub;

    assign ge = r_rem >= {1'b0, r_den};
    assign rem_sub = ge ? (r_rem - {1'b0, r_den}) : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= {1'b0, i_num};
                r_den  <= i_den;
                r_q    <= '0;
                r_cnt  <= CNT_W'(T_BITS + 1);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_q   <= {r_q[T_BITS-1:0], ge};
                r_rem <= {rem_sub[33:0], 1'b0};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

FILE: dv/homogeneous_triangle_clipper_unit_tb.sv
// Self-checking testbench for the homogeneous triangle clipper with a built-in clip predictor.
`timescale 1ns / 100ps
module homogeneous_triangle_clipper_unit_tb;
    import htc_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int DRAIN_CYCLES = 3000;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] w;
        logic last;
    } t_vertex_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [31:0] tri_in [12];
    logic o_valid;
    logic signed [31:0] o_out_x, o_out_y, o_out_z, o_out_w;
    logic o_last_vertex;

    t_vertex_word polygon_q [$];
    int sender_idle_pct = 0;
    int errors = 0;
    int triangles_sent = 0;
    int vertices_seen = 0;
    int quiet_cycles = 0;
    logic signed [31:0] next_tri [12];

    initial begin
        for (int i = 0; i < 12; i++) begin
            tri_in[i] = '0;
        end
    end

    always #5 i_clk = ~i_clk;

    homogeneous_triangle_clipper_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_a_x(tri_in[0]), .i_a_y(tri_in[1]), .i_a_z(tri_in[2]), .i_a_w(tri_in[3]),
        .i_b_x(tri_in[4]), .i_b_y(tri_in[5]), .i_b_z(tri_in[6]), .i_b_w(tri_in[7]),
        .i_c_x(tri_in[8]), .i_c_y(tri_in[9]), .i_c_z(tri_in[10]), .i_c_w(tri_in[11]),
        .o_valid(o_valid), .o_out_x(o_out_x), .o_out_y(o_out_y), .o_out_z(o_out_z),
        .o_out_w(o_out_w), .o_last_vertex(o_last_vertex)
    );

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    task automatic clip_triangle();
        longint poly [2][MAX_POLY_VERTS][4];
        longint xpt [4];
        longint d0, d1, delta, prod, q;
        logic [63:0] num, den, t, m_abs;
        int n, m, s, p, i, j, k, axis;
        bit in0, in1;
        t_vertex_word vw;
        for (i = 0; i < 3; i++) begin
            for (k = 0; k < 4; k++) begin
                poly[0][i][k] = longint'(next_tri[i * 4 + k]);
            end
        end
        n = 3;
        s = 0;
        for (p = 0; p < 6 && n > 0; p++) begin
            axis = p >> 1;
            m = 0;
            for (i = 0; i < n; i++) begin
                j = (i + 1) % n;
                d0 = (p % 2) ? poly[s][i][3] - poly[s][i][axis]
                             : poly[s][i][3] + poly[s][i][axis];
                d1 = (p % 2) ? poly[s][j][3] - poly[s][j][axis]
                             : poly[s][j][3] + poly[s][j][axis];
                in0 = d0 >= 0;
                in1 = d1 >= 0;
                if (in0 != in1) begin
                    num = mag(d0);
                    den = num + mag(d1);
                    t = (num << T_BITS) / den;
                    for (k = 0; k < 4; k++) begin
                        delta = poly[s][j][k] - poly[s][i][k];
                        prod = delta * longint'(t);
                        m_abs = mag(prod);
                        q = longint'((m_abs + (64'd1 << (T_BITS - 1))) >> T_BITS);
                        xpt[k] = sat32(prod < 0 ? poly[s][i][k] - q : poly[s][i][k] + q);
                    end
                    if (m < MAX_POLY_VERTS) begin
                        for (k = 0; k < 4; k++) poly[1 - s][m][k] = xpt[k];
                        m++;
                    end
                end
                if (in1 && m < MAX_POLY_VERTS) begin
                    for (k = 0; k < 4; k++) poly[1 - s][m][k] = poly[s][j][k];
                    m++;
                end
            end
            n = m;
            s = 1 - s;
        end
        for (i = 0; i < n; i++) begin
            vw.x = poly[s][i][0][31:0];
            vw.y = poly[s][i][1][31:0];
            vw.z = poly[s][i][2][31:0];
            vw.w = poly[s][i][3][31:0];
            vw.last = (i == n - 1);
            polygon_q.insert(polygon_q.size(), vw);
        end
    endtask

    task automatic send_triangle();
        for (int i = 0; i < 12; i++) begin
            tri_in[i] <= next_tri[i];
        end
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        clip_triangle();
        triangles_sent++;
        if ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < sender_idle_pct) @(posedge i_clk);
        end
    endtask

    task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                   input logic signed [31:0] want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_vertex_word want;
        if (i_rst_n && o_valid) begin
            vertices_seen++;
            if (polygon_q.size() == 0) begin
                report_mismatch("unexpected vertex x", o_out_x, 0);
            end else begin
                want = polygon_q.pop_front();
                if (o_out_x !== want.x) report_mismatch("x", o_out_x, want.x);
                if (o_out_y !== want.y) report_mismatch("y", o_out_y, want.y);
                if (o_out_z !== want.z) report_mismatch("z", o_out_z, want.z);
                if (o_out_w !== want.w) report_mismatch("w", o_out_w, want.w);
                if (o_last_vertex !== want.last) begin
                    report_mismatch("last", o_last_vertex, want.last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || o_valid || (start && !busy)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout with %0d vertices pending.", polygon_q.size());
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic set_vertex(input int v, input int x, input int y, input int z, input int w);
        next_tri[v * 4] = x;
        next_tri[v * 4 + 1] = y;
        next_tri[v * 4 + 2] = z;
        next_tri[v * 4 + 3] = w;
    endtask

    task automatic test_directed();
        int one;
        one = 32'h0001_0000;
        set_vertex(0, 0, 0, 0, one); set_vertex(1, one / 2, 0, 0, one);
        set_vertex(2, 0, one / 2, 0, one);
        send_triangle();
        set_vertex(0, 3 * one, 0, 0, one); set_vertex(1, 4 * one, one, 0, one);
        set_vertex(2, 5 * one, 0, one, one);
        send_triangle();
        for (int p = 0; p < 6; p++) begin
            for (int v = 0; v < 3; v++) set_vertex(v, 0, 0, 0, one);
            next_tri[p >> 1] = (p % 2) ? 2 * one : -2 * one;
            next_tri[4 + (p >> 1)] = (p % 2) ? one / 4 : -one / 4;
            next_tri[8 + ((p >> 1) + 1) % 3] = one / 2;
            send_triangle();
        end
        set_vertex(0, -3 * one, -3 * one, -3 * one, one);
        set_vertex(1, 3 * one, -3 * one, 3 * one, one);
        set_vertex(2, 0, 3 * one, 0, one);
        send_triangle();
        for (int v = 0; v < 3; v++) set_vertex(v, one / 3, -one / 5, one / 7, one);
        send_triangle();
        for (int v = 0; v < 3; v++) set_vertex(v, 0, 0, 0, 0);
        send_triangle();
        set_vertex(0, one, 0, 0, one); set_vertex(1, one, 0, 0, one);
        set_vertex(2, -one, 0, 0, one);
        send_triangle();
        set_vertex(0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
        set_vertex(1, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
        set_vertex(2, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000);
        send_triangle();
        set_vertex(0, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff);
        set_vertex(1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        set_vertex(2, 32'h7fffffff, 32'h80000000, 0, 32'h7fffffff);
        send_triangle();
        set_vertex(0, 0, 0, 0, -one); set_vertex(1, one, one, one, -one);
        set_vertex(2, 0, 0, 0, one);
        send_triangle();
        set_vertex(0, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        set_vertex(1, 1, 1, 1, 1); set_vertex(2, -1, 1, -1, 1);
        send_triangle();
    endtask

    task automatic test_random_shapes(input int count);
        int w, span, shift;
        for (int n = 0; n < count; n++) begin
            shift = $urandom_range(0, 14);
            for (int v = 0; v < 3; v++) begin
                w = int'($urandom_range(1, 32'h7fff) << shift);
                if ($urandom_range(9) == 0) w = -w;
                span = (w < 0) ? -w : w;
                for (int k = 0; k < 3; k++) begin
                    next_tri[v * 4 + k] =
                        int'($urandom_range(0, 32'h7fffffff) % (4 * longint'(span) + 1))
                        - 2 * span;
                end
                next_tri[v * 4 + 3] = w;
            end
            send_triangle();
        end
    endtask

    task automatic test_raw_noise(input int count);
        for (int n = 0; n < count; n++) begin
            for (int i = 0; i < 12; i++) next_tri[i] = $urandom;
            send_triangle();
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        sender_idle_pct = 0;
        test_random_shapes(70);
        test_raw_noise(10);
        sender_idle_pct = 85;
        test_random_shapes(60);
        test_raw_noise(10);
        sender_idle_pct = 28;
        test_random_shapes(60);
        test_raw_noise(10);
        sender_idle_pct = 0;
        test_random_shapes(60);
        test_raw_noise(20);
        start <= 1'b0;
        @(posedge i_clk);
        while (polygon_q.size() != 0 || busy) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Clipped %0d triangles (directed, bounded shapes and raw noise) into %0d vertices.",
                 triangles_sent, vertices_seen);
        $display("Sender gaps ran at 0, 85 and 28 percent; %0d mismatches.", errors);
        if (errors == 0 && polygon_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

FILE: files.f
+incdir+sv
sv/htc_pkg.sv
sv/htc_vcell.sv
sv/htc_div.sv
sv/homogeneous_triangle_clipper_unit.sv
dv/homogeneous_triangle_clipper_unit_tb.sv
